@@ sv/dhg_pkg.sv @@
// shared types, constants and codes of the diff hunk grouper
package dhg_pkg;

  // width of the edit index and of the running line counts
  localparam int unsigned IndexBits = 32;
  // width of the result fields on the output bus
  localparam int unsigned FieldBits = 32;
  localparam int unsigned CtxBits   = 10;
  localparam int unsigned GapBits   = CtxBits + 1;
  localparam int unsigned OpBits    = 2;
  localparam int unsigned InDataBits  = ((OpBits + 7) / 8) * 8;
  localparam int unsigned OutDataBits = 6 * FieldBits;

  localparam logic [CtxBits-1:0] CtxReset = CtxBits'(3);
  localparam logic [GapBits-1:0] GapMax   = {GapBits{1'b1}};

  typedef logic [IndexBits-1:0] idx_t;
  typedef logic [FieldBits-1:0] field_t;
  typedef logic [CtxBits-1:0]   ctx_t;
  typedef logic [GapBits-1:0]   gap_t;

  typedef enum logic [OpBits-1:0] {
    OP_COMMON = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  // running state of the grouper between beats
  typedef struct packed {
    idx_t edit_index;
    idx_t old_total;
    idx_t new_total;
    logic hunk_open;
    idx_t change_end;
    gap_t gap_commons;
    idx_t range_first;
    idx_t old_first;
    idx_t new_first;
    logic new_first_pending;
    idx_t old_span;
    idx_t new_span;
  } dhg_state_t;

  // one closed hunk
  typedef struct packed {
    field_t new_count;
    field_t new_start;
    field_t old_count;
    field_t old_start;
    field_t last_edit;
    field_t first_edit;
  } dhg_hunk_t;

endpackage

@@ sv/diff_hunk_grouper_unit.sv @@
// top level of the diff hunk grouper: input register, step logic, hunk register
//
//  channel   dir  handshake            payload
//  s_axis    in   tvalid/tready        tdata[1:0] op, tlast marks final edit
//  m_axis    out  tvalid/tready        tdata: six 32-bit hunk fields
//  cfg       in   valid/ready          data: context_lines (10 bits)
//
// one edit symbol per cycle unless m_axis stalls; path: input register, then hunk register
// the step logic between the input register and the hunk register sets the rate
// a stalled output holds the hunk register and, once the input register is full, s_axis
// cfg is taken only while the input register is empty, so no edit in flight sees a new context
// reset clears the stream state and sets context_lines to 3
// the stream state returns to zero after the edit marked last
module diff_hunk_grouper_unit (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // op [1:0], zero padding above
  input  logic [dhg_pkg::InDataBits-1:0]   s_axis_tdata_i,
  input  logic                             s_axis_tlast_i,

  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // first_edit, last_edit, old_start, old_count, new_start, new_count (lowest first)
  output logic [dhg_pkg::OutDataBits-1:0]  m_axis_tdata_o,

  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  dhg_pkg::ctx_t                    cfg_data_i
);
  import dhg_pkg::*;

  // context register, written only with the input register empty
  ctx_t ctx_q;

  // input register
  logic              in_valid_q;
  logic [OpBits-1:0] in_op_q;
  logic              in_last_q;

  // stream state and hunk register
  dhg_state_t state_q, state_d;
  logic       out_valid_q;
  dhg_hunk_t  hunk_q, hunk_d;
  logic       emit;

  logic advance, fire;

  // the pipe moves whenever the hunk register is free or being drained
  assign advance = !out_valid_q || m_axis_tready_i;
  assign fire    = in_valid_q && advance;

  assign s_axis_tready_o = !in_valid_q || advance;
  assign cfg_ready_o     = !in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= CtxReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ctx_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // payload of the input beat, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_op_q   <= s_axis_tdata_i[OpBits-1:0];
      in_last_q <= s_axis_tlast_i;
    end
  end

  dhg_step u_step (
    .state_i (state_q),
    .op_i    (in_op_q),
    .last_i  (in_last_q),
    .ctx_i   (ctx_q),
    .state_o (state_d),
    .emit_o  (emit),
    .hunk_o  (hunk_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      hunk_q <= hunk_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = hunk_q;

  // a full input register must not be overwritten while the hunk register stalls
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while the pipe is stalled");

  // the edit marked last leaves the stream state cleared
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_last_q) |=> (state_q.edit_index == '0 && !state_q.hunk_open))
    else $error("stream state not cleared after last edit");

  // a pending new start only exists inside an open hunk
  a_pending_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.new_first_pending |-> state_q.hunk_open)
    else $error("new start pending with no open hunk");

  // a hunk beat appears only after a processed edit
  a_out_from_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire))
    else $error("hunk beat without a processed edit");

endmodule

@@ sv/dhg_step.sv @@
// next-state and hunk logic for one edit symbol
module dhg_step (
  input  dhg_pkg::dhg_state_t state_i,
  input  logic [dhg_pkg::OpBits-1:0] op_i,
  input  logic                 last_i,
  input  dhg_pkg::ctx_t        ctx_i,
  output dhg_pkg::dhg_state_t  state_o,
  output logic                 emit_o,
  output dhg_pkg::dhg_hunk_t   hunk_o
);
  import dhg_pkg::*;

  logic       is_ins, is_del, is_change;
  gap_t       ctx_ext, pre, gap_inc, close_gap;
  idx_t       pre_idx, gap_idx, del_idx, ins_idx, old_after, new_after, tail_idx;
  dhg_state_t mid;
  logic       close_common;

  always_comb begin
    case (op_e'(op_i))
      OP_INSERT: begin
        is_ins = 1'b1;
        is_del = 1'b0;
      end
      OP_DELETE: begin
        is_ins = 1'b0;
        is_del = 1'b1;
      end
      default: begin
        // common, and the unused code handled as common
        is_ins = 1'b0;
        is_del = 1'b0;
      end
    endcase
  end

  assign is_change = is_ins | is_del;
  assign ctx_ext   = GapBits'(ctx_i);
  assign pre       = (state_i.gap_commons < ctx_ext) ? state_i.gap_commons : ctx_ext;
  assign pre_idx   = IndexBits'(pre);
  assign gap_idx   = IndexBits'(state_i.gap_commons);
  assign del_idx   = IndexBits'(is_del);
  assign ins_idx   = IndexBits'(is_ins);
  assign old_after = state_i.old_total + del_idx;
  assign new_after = state_i.new_total + ins_idx;
  assign gap_inc   = (state_i.gap_commons < GapMax) ? state_i.gap_commons + gap_t'(1)
                                                    : state_i.gap_commons;
  assign close_gap = {ctx_i, 1'b1};

  always_comb begin
    mid          = state_i;
    close_common = 1'b0;
    if (is_change) begin
      if (!state_i.hunk_open) begin
        mid.hunk_open   = 1'b1;
        mid.range_first = state_i.edit_index - pre_idx;
        if (pre != '0) begin
          mid.old_first         = state_i.old_total - pre_idx + idx_t'(1);
          mid.new_first         = state_i.new_total - pre_idx + idx_t'(1);
          mid.new_first_pending = 1'b0;
        end else begin
          mid.old_first         = old_after;
          mid.new_first         = new_after;
          mid.new_first_pending = is_del;
        end
        mid.old_span = pre_idx + del_idx;
        mid.new_span = pre_idx + ins_idx;
      end else begin
        mid.old_span = state_i.old_span + gap_idx + del_idx;
        mid.new_span = state_i.new_span + gap_idx + ins_idx;
        if (state_i.new_first_pending && is_ins) begin
          mid.new_first         = new_after;
          mid.new_first_pending = 1'b0;
        end
      end
      mid.change_end  = state_i.edit_index;
      mid.gap_commons = '0;
      mid.old_total   = old_after;
      mid.new_total   = new_after;
    end else begin
      mid.old_total   = state_i.old_total + idx_t'(1);
      mid.new_total   = state_i.new_total + idx_t'(1);
      mid.gap_commons = gap_inc;
      if (state_i.hunk_open) begin
        if (state_i.new_first_pending && (gap_inc <= ctx_ext)) begin
          mid.new_first         = state_i.new_total + idx_t'(1);
          mid.new_first_pending = 1'b0;
        end
        close_common = (gap_inc == close_gap);
      end
    end
    mid.edit_index = state_i.edit_index + idx_t'(1);
  end

  // trailing context of the hunk that closes on this beat
  assign tail_idx = IndexBits'((mid.gap_commons < ctx_ext) ? mid.gap_commons : ctx_ext);

  assign emit_o = mid.hunk_open && (close_common || last_i);

  assign hunk_o.first_edit = FieldBits'(mid.range_first);
  assign hunk_o.last_edit  = FieldBits'(mid.change_end + tail_idx);
  assign hunk_o.old_start  = FieldBits'(mid.old_first);
  assign hunk_o.old_count  = FieldBits'(mid.old_span + tail_idx);
  assign hunk_o.new_start  = FieldBits'(mid.new_first);
  assign hunk_o.new_count  = FieldBits'(mid.new_span + tail_idx);

  always_comb begin
    state_o = mid;
    if (last_i) begin
      state_o = '0;
    end else if (close_common) begin
      state_o.hunk_open         = 1'b0;
      state_o.new_first_pending = 1'b0;
    end
  end

endmodule
